@@ sv/clbs_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// clbs_pkg: shared types and constants
// Payload structs, command codes and controller/datapath command types.
// ----------------------------------------------------------------------------
package clbs_pkg;

  localparam int unsigned COLUMNS = 40;

  localparam logic [2:0] CMD_INSTR = 3'd0;
  localparam logic [2:0] CMD_CHAR  = 3'd1;
  localparam logic [2:0] CMD_CURS  = 3'd2;
  localparam logic [2:0] CMD_NUM   = 3'd3;
  localparam logic [2:0] CMD_CLEAR = 3'd4;
  localparam logic [2:0] CMD_INIT  = 3'd5;

  localparam logic [7:0] ROW1_OFFSET = 8'h40;
  localparam logic [7:0] ADDR_CMD    = 8'h80;
  localparam logic [7:0] ASCII_ZERO  = 8'd48;
  localparam logic [7:0] ASCII_MINUS = 8'h2d;
  localparam logic [7:0] CLEAR_BYTE  = 8'h01;

  // Reciprocal of ten: (n * DIV10_RECIP) >> 35 equals n / 10 for any 32-bit n.
  localparam logic [31:0] DIV10_RECIP = 32'hCCCCCCCD;

  typedef struct packed {
    logic [2:0]         command;
    logic [7:0]         byte_value;
    logic [5:0]         column;
    logic               row;
    logic signed [31:0] number;
  } in_req_t;

  typedef struct packed {
    logic        rs_level;
    logic [7:0]  bus_value;
    logic [15:0] wait_before_us;
    logic        last;
  } out_xfer_t;

  // Controller -> datapath commands.
  typedef struct packed {
    logic load;      // capture request
    logic div_step;  // one step of the divide by ten
    logic div_start; // start a digit extraction
    logic push_dig;  // push remainder digit
    logic pop_dig;   // pop a digit for output
  } dp_cmd_t;

  // Datapath -> controller status.
  typedef struct packed {
    logic div_done;
    logic quot_zero;
    logic dig_empty;
    logic neg;
  } dp_sts_t;

  function automatic logic [7:0] init_byte(input logic mode4, input logic [2:0] idx);
    logic [7:0] b;
    b = 8'h00;
    if (mode4) begin
      case (idx)
        3'd0: b = 8'h02;
        3'd1: b = 8'h28;
        3'd2: b = 8'h00;
        3'd3: b = 8'h0C;
        3'd4: b = 8'h00;
        3'd5: b = 8'h01;
        3'd6: b = 8'h00;
        3'd7: b = 8'h06;
        default: b = 8'h00;
      endcase
    end else begin
      case (idx[1:0])
        2'd0: b = 8'h3C;
        2'd1: b = 8'h0E;
        2'd2: b = 8'h01;
        2'd3: b = 8'h06;
        default: b = 8'h00;
      endcase
    end
    return b;
  endfunction

  function automatic logic [15:0] init_wait(input logic mode4, input logic [2:0] idx);
    logic [15:0] w;
    w = 16'd0;
    if (mode4) begin
      case (idx)
        3'd0: w = 16'd50000;
        3'd2: w = 16'd50;
        3'd4: w = 16'd50;
        3'd6: w = 16'd2000;
        default: w = 16'd10;
      endcase
    end else begin
      case (idx[1:0])
        2'd0: w = 16'd50000;
        2'd3: w = 16'd2000;
        default: w = 16'd50;
      endcase
    end
    return w;
  endfunction

endpackage
`default_nettype wire

@@ sv/clbs_datapath.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// clbs_datapath: request capture and decimal conversion
// Holds the request, divides the magnitude by ten in two steps by reciprocal
// multiplication and stacks the digits.
// ----------------------------------------------------------------------------
module clbs_datapath import clbs_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire in_req_t  req_in,
  input  wire dp_cmd_t  cmd,
  output in_req_t       req_q,
  output logic [3:0]    dig_top,
  output dp_sts_t       sts
);

  in_req_t     req_r;
  logic [31:0] quo_r, quo_nxt;
  logic [31:0] q10_r, q10_nxt;
  logic [3:0]  rem_r, rem_nxt;
  logic        phase_r, phase_nxt;
  logic        busy_r, busy_nxt;
  logic [3:0]  dig_r [10];
  logic [3:0]  sp_r, sp_nxt;
  logic [63:0] prod;
  logic [31:0] q_times10;

  assign prod      = 64'(quo_r) * 64'(DIV10_RECIP);
  assign q_times10 = {q10_r[28:0], 3'b000} + {q10_r[30:0], 1'b0};

  always_comb begin
    quo_nxt   = quo_r;
    q10_nxt   = q10_r;
    rem_nxt   = rem_r;
    phase_nxt = phase_r;
    busy_nxt  = busy_r;
    sp_nxt    = sp_r;
    if (cmd.load) begin
      quo_nxt = req_in.number[31] ? (32'd0 - req_in.number) : req_in.number;
      sp_nxt  = 4'd0;
    end
    if (cmd.div_start) begin
      rem_nxt   = 4'd0;
      phase_nxt = 1'b0;
      busy_nxt  = 1'b1;
    end else if (cmd.div_step && busy_r) begin
      if (!phase_r) begin
        // First step: the quotient from the reciprocal product.
        q10_nxt   = {3'b000, prod[63:35]};
        phase_nxt = 1'b1;
      end else begin
        // Second step: the remainder from the quotient.
        rem_nxt  = 4'(quo_r - q_times10);
        quo_nxt  = q10_r;
        busy_nxt = 1'b0;
      end
    end
    if (cmd.push_dig) sp_nxt = sp_r + 4'd1;
    else if (cmd.pop_dig) sp_nxt = sp_r - 4'd1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r  <= 1'b0;
      phase_r <= 1'b0;
      sp_r    <= 4'd0;
    end else begin
      busy_r  <= busy_nxt;
      phase_r <= phase_nxt;
      sp_r    <= sp_nxt;
    end
    if (cmd.load) req_r <= req_in;
    quo_r <= quo_nxt;
    q10_r <= q10_nxt;
    rem_r <= rem_nxt;
    if (cmd.push_dig) dig_r[sp_r] <= rem_r;
  end

  assign req_q          = req_r;
  assign dig_top        = dig_r[4'(sp_r - 4'd1)];
  assign sts.div_done   = !busy_r;
  assign sts.quot_zero  = (quo_r == 32'd0);
  assign sts.dig_empty  = (sp_r == 4'd0);
  assign sts.neg        = req_r.number[31];

endmodule
`default_nettype wire

@@ sv/clbs_ctrl.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// clbs_ctrl: sequencing state machine
// Walks each request's transfers and drives the output register.
// ----------------------------------------------------------------------------
module clbs_ctrl import clbs_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_ready,
  input  wire logic      mode4,
  input  wire in_req_t   req_q,
  input  wire logic [3:0] dig_top,
  input  wire dp_sts_t   sts,
  output dp_cmd_t        cmd,
  output out_xfer_t      out_data,
  output logic           out_valid,
  input  wire logic      out_ready
);

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_DISP = 6'b000010,
    S_DIV  = 6'b000100,
    S_DIGS = 6'b001000,
    S_EMIT = 6'b010000,
    S_INIT = 6'b100000
  } state_t;

  state_t     state_r, state_nxt;
  out_xfer_t  out_r, out_nxt;
  logic       ov_r, ov_nxt;
  logic       lo_r, lo_nxt;      // second nibble pending
  logic       minus_r, minus_nxt; // minus sign still to send
  logic [7:0] byte_r, byte_nxt;
  logic       rs_r, rs_nxt;
  logic [15:0] wt_r, wt_nxt;
  logic       fin_r, fin_nxt;    // current byte ends the request
  logic [2:0] idx_r, idx_nxt;
  logic       free;
  logic [5:0] col;

  assign free = !ov_r || out_ready;
  assign col  = (req_q.column >= 6'(COLUMNS)) ? 6'(COLUMNS - 1) : req_q.column;

  always_comb begin
    state_nxt = state_r;
    out_nxt   = out_r;
    ov_nxt    = ov_r && !out_ready;
    lo_nxt    = lo_r;
    minus_nxt = minus_r;
    byte_nxt  = byte_r;
    rs_nxt    = rs_r;
    wt_nxt    = wt_r;
    fin_nxt   = fin_r;
    idx_nxt   = idx_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_DISP;
        end
      end
      S_DISP: begin
        rs_nxt  = 1'b0;
        wt_nxt  = 16'd0;
        fin_nxt = 1'b1;
        lo_nxt  = 1'b0;
        case (req_q.command)
          CMD_INSTR: begin byte_nxt = req_q.byte_value; state_nxt = S_EMIT; end
          CMD_CHAR: begin
            byte_nxt = req_q.byte_value; rs_nxt = 1'b1; state_nxt = S_EMIT;
          end
          CMD_CURS: begin
            byte_nxt  = ADDR_CMD + {2'b00, col} + (req_q.row ? ROW1_OFFSET : 8'h00);
            state_nxt = S_EMIT;
          end
          CMD_CLEAR: begin byte_nxt = CLEAR_BYTE; state_nxt = S_EMIT; end
          CMD_NUM: begin
            minus_nxt     = sts.neg;
            cmd.div_start = 1'b1;
            state_nxt     = S_DIV;
          end
          CMD_INIT: begin idx_nxt = 3'd0; state_nxt = S_INIT; end
          default: state_nxt = S_IDLE;
        endcase
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_done) begin
          cmd.push_dig = 1'b1;
          cmd.div_step = 1'b0;
          state_nxt    = S_DIGS;
        end
      end
      S_DIGS: begin
        // Quotient now holds the last dividend / 10; continue until it reaches zero.
        if (!sts.quot_zero) begin
          cmd.div_start = 1'b1;
          state_nxt     = S_DIV;
        end else if (minus_r) begin
          minus_nxt = 1'b0;
          byte_nxt  = ASCII_MINUS; rs_nxt = 1'b1; wt_nxt = 16'd0; fin_nxt = 1'b0;
          state_nxt = S_EMIT;
        end else begin
          cmd.pop_dig = 1'b1;
          byte_nxt  = ASCII_ZERO + {4'd0, dig_top};
          rs_nxt    = 1'b1; wt_nxt = 16'd0;
          fin_nxt   = 1'b0;
          state_nxt = S_EMIT;
        end
      end
      S_INIT: begin
        byte_nxt  = init_byte(mode4, idx_r);
        wt_nxt    = init_wait(mode4, idx_r);
        rs_nxt    = 1'b0;
        fin_nxt   = mode4 ? (idx_r == 3'd7) : (idx_r == 3'd3);
        idx_nxt   = idx_r + 3'd1;
        state_nxt = S_EMIT;
      end
      S_EMIT: begin
        if (free) begin
          ov_nxt    = 1'b1;
          out_nxt.rs_level = rs_r;
          if (mode4 && !lo_r) begin
            out_nxt.bus_value      = {4'd0, byte_r[7:4]};
            out_nxt.wait_before_us = wt_r;
            out_nxt.last           = 1'b0;
            lo_nxt                 = 1'b1;
          end else begin
            out_nxt.bus_value      = mode4 ? {4'd0, byte_r[3:0]} : byte_r;
            out_nxt.wait_before_us = mode4 ? 16'd0 : wt_r;
            lo_nxt                 = 1'b0;
            if (req_q.command == CMD_NUM) begin
              // The number ends once the digit stack has been emptied.
              if (sts.dig_empty) begin
                out_nxt.last = 1'b1;
                state_nxt    = S_IDLE;
              end else begin
                out_nxt.last = 1'b0;
                state_nxt    = S_DIGS;
              end
            end else begin
              out_nxt.last = fin_r;
              state_nxt    = fin_r ? S_IDLE : (req_q.command == CMD_INIT ? S_INIT : S_IDLE);
            end
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      ov_r    <= 1'b0;
      lo_r    <= 1'b0;
      minus_r <= 1'b0;
      idx_r   <= 3'd0;
    end else begin
      state_r <= state_nxt;
      ov_r    <= ov_nxt;
      lo_r    <= lo_nxt;
      minus_r <= minus_nxt;
      idx_r   <= idx_nxt;
    end
    out_r  <= out_nxt;
    byte_r <= byte_nxt;
    rs_r   <= rs_nxt;
    wt_r   <= wt_nxt;
    fin_r  <= fin_nxt;
  end

  assign out_data  = out_r;
  assign out_valid = ov_r;

endmodule
`default_nettype wire

@@ sv/char_lcd_bus_sequencer.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// char_lcd_bus_sequencer: character LCD bus transfer sequencer
// Turns LCD requests into register-select / data / wait transfers.
// ----------------------------------------------------------------------------
// Usage: a request enters on in_valid/in_ready with its fields in in_data.
// The block takes one request at a time; in_ready is high only while no
// request is being worked on. Each request yields one or more transfers on
// out_valid/out_ready, the final one flagged by last. Unknown commands
// produce no transfers.
// Printing a number extracts one decimal digit at a time with a two-step
// divide by ten by reciprocal multiplication, then sends the characters.
// The output sits in a register; when the receiver stalls the sequencer
// holds its place and resumes once the transfer is taken.
// Reset (rst_n low at a clock edge) returns to idle, drops any pending
// transfer and sets bus_mode to 8-bit. bus_mode is written by cfg_we and
// should change only while the block is idle.
// ----------------------------------------------------------------------------
module char_lcd_bus_sequencer import clbs_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_ready,
  input  wire in_req_t   in_data,
  output logic           out_valid,
  input  wire logic      out_ready,
  output out_xfer_t      out_data,
  input  wire logic      cfg_we,
  input  wire logic      cfg_wdata
);

  logic       mode_r;
  in_req_t    req_q;
  logic [3:0] dig_top;
  dp_cmd_t    cmd;
  dp_sts_t    sts;

  always_ff @(posedge clk) begin
    if (!rst_n) mode_r <= 1'b0;
    else if (cfg_we) mode_r <= cfg_wdata;
  end

  clbs_datapath u_dp (
    .clk, .rst_n, .req_in(in_data), .cmd, .req_q, .dig_top, .sts
  );

  clbs_ctrl u_ctrl (
    .clk, .rst_n, .in_valid, .in_ready, .mode4(mode_r), .req_q, .dig_top,
    .sts, .cmd, .out_data, .out_valid, .out_ready
  );

endmodule
`default_nettype wire

@@ sv/clbs_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clbs_checker: port-level checks
// Watches the request and transfer channels of the sequencer.
// ----------------------------------------------------------------------------
module clbs_checker import clbs_pkg::*; (
  input logic      clk,
  input logic      rst_n,
  input logic      in_valid,
  input logic      in_ready,
  input logic      out_valid,
  input logic      out_ready,
  input out_xfer_t out_data
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("transfer changed while stalled");

  a_busy_no_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("request taken while busy");

  a_idle_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.last |-> !in_ready)
    else $error("ready before last transfer");

  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("transfer after reset");

endmodule

bind char_lcd_bus_sequencer clbs_checker u_chk (
  .clk, .rst_n, .in_valid, .in_ready, .out_valid, .out_ready, .out_data
);
